### rtl/core/gss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gss_pkg
// Shared types and constants for the Gauss-Seidel sweep engine.
// ---------------------------------------------------------------------------
package gss_pkg;

  // Default number of rows the stores hold.
  localparam int DEF_MAX_DIM = 16;
  // Largest sweep the 4-bit row index can describe.
  localparam int SWEEP_CAP   = 16;
  localparam int DIM_W       = 5;
  localparam logic [DIM_W-1:0] DIM_RESET = 5'd3;

  // Fraction bits of the Q16.16 estimates.
  localparam int Q_FRAC = 16;
  // Numerator width: sixteen 16x32 products plus the scaled rhs.
  localparam int NUM_W  = 56;
  localparam int PROD_W = 48;

  // Item commands.
  localparam logic [1:0] CMD_LOAD_COEF = 2'd0;
  localparam logic [1:0] CMD_LOAD_RHS  = 2'd1;
  localparam logic [1:0] CMD_LOAD_EST  = 2'd2;
  localparam logic [1:0] CMD_SWEEP     = 2'd3;

  // One result item from the core.
  typedef struct packed {
    logic [3:0]  index;
    logic [31:0] estimate;
    logic        zero_pivot;
    logic        last;
  } gss_res_t;

endpackage
`default_nettype wire

### rtl/core/gss_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gss_div
// Restoring signed divider, one quotient bit per cycle, with truncation
// toward zero and saturation of the quotient to 32 bits.
// ---------------------------------------------------------------------------
module gss_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [gss_pkg::NUM_W-1:0] num,
  input  wire logic [15:0]               den,
  output logic                           done,
  output logic [31:0]                    quot
);
  import gss_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] q_r;
  logic [16:0]      rem_r;
  logic [15:0]      dm_r;
  logic             neg_r;
  logic             done_r;
  logic [31:0]      quot_r;

  logic [16:0]      rem_sh;
  logic             take;
  logic [NUM_W-1:0] q_nxt;
  logic [NUM_W-1:0] nmag;
  logic [15:0]      dmag;

  // Operand magnitudes.
  always_comb begin
    nmag = num[NUM_W-1] ? (~num + NUM_W'(1)) : num;
    dmag = den[15] ? (~den + 16'd1) : den;
  end

  // One restoring step.
  always_comb begin
    rem_sh = {rem_r[15:0], q_r[NUM_W-1]};
    take   = rem_sh >= {1'b0, dm_r};
    q_nxt  = {q_r[NUM_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
        q_r    <= nmag;
        rem_r  <= '0;
        dm_r   <= dmag;
        neg_r  <= num[NUM_W-1] ^ den[15];
      end else if (busy_r) begin
        q_r   <= q_nxt;
        rem_r <= take ? (rem_sh - {1'b0, dm_r}) : rem_sh;
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Apply the sign and clip to the Q16.16 range once the last bit is in.
  always_ff @(posedge clk) begin
    if (busy_r && cnt_r == CNT_W'(1)) begin
      if (neg_r) begin
        if (q_nxt > NUM_W'(64'h8000_0000)) quot_r <= 32'h8000_0000;
        else quot_r <= 32'(~q_nxt + NUM_W'(1));
      end else begin
        if (q_nxt > NUM_W'(64'h7FFF_FFFF)) quot_r <= 32'h7FFF_FFFF;
        else quot_r <= q_nxt[31:0];
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule
`default_nettype wire

### rtl/core/gss_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gss_core
// Coefficient, rhs and estimate memories with the row sequencer, the
// multiply-accumulate pipeline and the shared divider.
// ---------------------------------------------------------------------------
module gss_core #(
  parameter int MAX_DIM = gss_pkg::DEF_MAX_DIM
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [gss_pkg::DIM_W-1:0] dim_used,
  input  wire logic                      item_fire,
  input  wire logic [1:0]                cmd,
  input  wire logic [3:0]                row,
  input  wire logic [3:0]                col,
  input  wire logic [15:0]               coef_value,
  input  wire logic [31:0]               estimate_value,
  output logic                           idle,
  output logic                           res_valid,
  input  wire logic                      res_ready,
  output gss_pkg::gss_res_t              res
);
  import gss_pkg::*;

  localparam int AW = $clog2(MAX_DIM);
  localparam int RW = 6;
  localparam int SWEEP_MAX = (MAX_DIM < SWEEP_CAP) ? MAX_DIM : SWEEP_CAP;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RHS   = 3'd1;
  localparam logic [2:0] S_MAC   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_DIVW  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  // Memories.
  logic [15:0] coef_mem [2**(2*AW)];
  logic [15:0] rhs_mem  [MAX_DIM];
  logic [31:0] est_mem  [MAX_DIM];
  logic [MAX_DIM-1:0] est_vld_r;

  logic [2:0]       state_r;
  logic [DIM_W-1:0] dim_r;
  logic [DIM_W-1:0] r_r;
  logic [DIM_W-1:0] c_r;

  logic [15:0] coef_rd_r;
  logic [15:0] rhs_rd_r;
  logic [31:0] est_rd_r;

  logic        s1_r, s1_piv_r, s2_r;
  logic [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_s;
  logic [NUM_W-1:0]  acc_r;
  logic [15:0] piv_r;
  logic [31:0] xold_r;
  logic [31:0] result_r;
  logic        zp_r;

  logic        div_start;
  logic        div_done;
  logic [31:0] div_quot;

  logic [DIM_W-1:0] dim_sel;
  logic [AW-1:0]    ld_row;
  logic [AW-1:0]    ld_col;
  logic             row_ok;
  logic             col_ok;
  logic [AW-1:0]    r_a;
  logic [AW-1:0]    c_a;
  logic             mac_rd;
  logic             wb_fire;

  // Load addressing and the clipped sweep length.
  always_comb begin
    ld_row  = AW'(row);
    ld_col  = AW'(col);
    row_ok  = RW'(row) < RW'(MAX_DIM);
    col_ok  = RW'(col) < RW'(MAX_DIM);
    r_a     = AW'(r_r);
    c_a     = AW'(c_r);
    dim_sel = (dim_used > DIM_W'(SWEEP_MAX)) ? DIM_W'(SWEEP_MAX) : dim_used;
    mac_rd  = state_r == S_MAC;
    wb_fire = state_r == S_OUT && res_ready;
    div_start = state_r == S_DIV;
  end

  // Coefficient memory.
  always_ff @(posedge clk) begin
    if (item_fire && cmd == CMD_LOAD_COEF && row_ok && col_ok) begin
      coef_mem[{ld_row, ld_col}] <= coef_value;
    end
    coef_rd_r <= coef_mem[{r_a, c_a}];
  end

  // Rhs memory.
  always_ff @(posedge clk) begin
    if (item_fire && cmd == CMD_LOAD_RHS && row_ok) begin
      rhs_mem[ld_row] <= coef_value;
    end
    rhs_rd_r <= rhs_mem[r_a];
  end

  // Estimate memory; an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (item_fire && cmd == CMD_LOAD_EST && row_ok) begin
      est_mem[ld_row] <= estimate_value;
    end else if (wb_fire) begin
      est_mem[r_a] <= result_r;
    end
    est_rd_r <= est_vld_r[c_a] ? est_mem[c_a] : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_vld_r <= '0;
    end else if (item_fire && cmd == CMD_LOAD_EST && row_ok) begin
      est_vld_r[ld_row] <= 1'b1;
    end else if (wb_fire) begin
      est_vld_r[r_a] <= 1'b1;
    end
  end

  // Multiply-accumulate pipeline: read, multiply, subtract.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r     <= 1'b0;
      s1_piv_r <= 1'b0;
      s2_r     <= 1'b0;
    end else begin
      s1_r     <= mac_rd;
      s1_piv_r <= mac_rd && c_r == r_r;
      s2_r     <= s1_r;
    end
  end

  // Signed coefficient times estimate, formed at the full product width.
  assign prod_s = $signed(coef_rd_r) * $signed(est_rd_r);

  always_ff @(posedge clk) begin
    if (s1_r) begin
      prod_r <= s1_piv_r ? '0 : prod_s;
    end
    if (s1_piv_r) begin
      piv_r  <= coef_rd_r;
      xold_r <= est_rd_r;
    end
    if (mac_rd && c_r == '0) begin
      acc_r <= {{(NUM_W-16-Q_FRAC){rhs_rd_r[15]}}, rhs_rd_r, {Q_FRAC{1'b0}}};
    end else if (s2_r) begin
      acc_r <= acc_r - {{(NUM_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
    if (state_r == S_DRAIN && !s1_r && !s2_r && piv_r == 16'd0) begin
      result_r <= xold_r;
      zp_r     <= 1'b1;
    end else if (state_r == S_DIVW && div_done) begin
      result_r <= div_quot;
      zp_r     <= 1'b0;
    end
  end

  // Row sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      r_r     <= '0;
      c_r     <= '0;
      dim_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          r_r <= '0;
          c_r <= '0;
          if (item_fire && cmd == CMD_SWEEP && dim_sel != '0) begin
            dim_r   <= dim_sel;
            state_r <= S_RHS;
          end
        end
        S_RHS: begin
          c_r     <= '0;
          state_r <= S_MAC;
        end
        S_MAC: begin
          if (c_r == dim_r - DIM_W'(1)) state_r <= S_DRAIN;
          else c_r <= c_r + DIM_W'(1);
        end
        S_DRAIN: begin
          if (!s1_r && !s2_r) begin
            state_r <= (piv_r == 16'd0) ? S_OUT : S_DIV;
          end
        end
        S_DIV: begin
          state_r <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) state_r <= S_OUT;
        end
        S_OUT: begin
          if (res_ready) begin
            if (r_r == dim_r - DIM_W'(1)) begin
              state_r <= S_IDLE;
            end else begin
              r_r     <= r_r + DIM_W'(1);
              state_r <= S_RHS;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  gss_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (acc_r),
    .den   (piv_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign idle           = state_r == S_IDLE;
  assign res_valid      = state_r == S_OUT;
  assign res.index      = 4'(r_r);
  assign res.estimate   = result_r;
  assign res.zero_pivot = zp_r;
  assign res.last       = r_r == dim_r - DIM_W'(1);

endmodule
`default_nettype wire

### rtl/core/gauss_seidel_sweep.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gauss_seidel_sweep
// Gauss-Seidel solver: loads A, b and x, and runs in-place sweeps.
// ---------------------------------------------------------------------------
//  Channel  Direction  Carries
//  in_      slave      load coefficient / rhs / estimate, or a sweep command
//  out_     master     one new estimate per row, tlast on the final row
//  cfg_     write      dim_used
//
// A sweep runs row by row: a multiply-accumulate pass over the memories, then
// a start and run of the bit-serial divider (56 quotient bits, one per cycle),
// then the item is handed on; a row with a zero pivot skips the divider and
// hands on its old estimate.
// in_tready is low while a sweep runs. A stalled out_ channel holds the
// sequencer at the current row. Reset clears the estimates to zero.
// ---------------------------------------------------------------------------
module gauss_seidel_sweep #(
  parameter int MAX_DIM = gss_pkg::DEF_MAX_DIM
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // row[3:0], col[7:4], coef_value[23:8], estimate_value[55:24]
  input  wire logic [55:0] in_tdata,
  // cmd[1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // index[3:0], estimate[35:4], zeros above
  output logic [39:0]      out_tdata,
  // zero_pivot[0]
  output logic             out_tuser,
  output logic             out_tlast,
  input  wire logic        cfg_wr_en,
  input  wire logic [4:0]  cfg_wr_data
);
  import gss_pkg::*;

  logic [DIM_W-1:0] dim_r;
  logic             core_idle;
  logic             item_fire;
  logic             res_valid;
  logic             res_ready;
  gss_res_t         res;
  logic             out_valid_r;
  gss_res_t         out_r;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) dim_r <= DIM_RESET;
    else if (cfg_wr_en) dim_r <= cfg_wr_data;
  end

  assign in_tready = core_idle;
  assign item_fire = in_tvalid && core_idle;

  gss_core #(.MAX_DIM(MAX_DIM)) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .dim_used       (dim_r),
    .item_fire      (item_fire),
    .cmd            (in_tuser),
    .row            (in_tdata[3:0]),
    .col            (in_tdata[7:4]),
    .coef_value     (in_tdata[23:8]),
    .estimate_value (in_tdata[55:24]),
    .idle           (core_idle),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res            (res)
  );

  // Output register; refilled in the cycle it is taken.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) out_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_r.estimate, out_r.index};
  assign out_tuser  = out_r.zero_pivot;
  assign out_tlast  = out_r.last;

endmodule
`default_nettype wire
